// File: src/indexed_set_swap_erase_top_assert.svh
// Assertion macros for the indexed set block, empty when synthesizing.
`ifndef INDEXED_SET_SWAP_ERASE_TOP_ASSERT_SVH
`define INDEXED_SET_SWAP_ERASE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define ISSE_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ISSE_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ISSE_ASSERT(label, clk, rst_n, prop, msg)
`define ISSE_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// File: src/isse_pkg.sv
// Shared constants, codes and beat types of the indexed set block.
package isse_pkg;

  localparam int MAX_ELEMS = 1024;
  localparam int IDX_W     = $clog2(MAX_ELEMS);
  localparam int CNT_W     = $clog2(MAX_ELEMS + 1);
  localparam int ELEM_W    = 10;
  localparam int ACT_W     = 2;
  localparam int STAT_W    = 2;
  localparam int OCNT_W    = 11;
  localparam int UNIV_W    = 11;

  localparam logic [UNIV_W-1:0] UNIV_RESET = UNIV_W'(1024);

  localparam logic [ACT_W-1:0] ACT_FILL   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_APPEND = 2'd1;
  localparam logic [ACT_W-1:0] ACT_ERASE  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_DONE   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_ABSENT = 2'd1;
  localparam logic [STAT_W-1:0] STAT_REJECT = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [ELEM_W-1:0] element;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [OCNT_W-1:0] member_count;
    logic [ELEM_W-1:0] moved_element;
  } out_item_t;

  typedef struct packed {
    logic latch_in;
    logic slot_rd;
    logic chk;
    logic mov;
    logic app;
    logic rsp;
    logic sweep_start;
    logic sweep_step;
    logic sweep_fill;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic sweep_last;
    logic in_range;
  } dp_sts_t;

endpackage

// File: src/isse_ctrl.sv
// Controller state machine that sequences fill, append and erase commands.
module isse_ctrl import isse_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [ACT_W-1:0] in_action,
  output logic             in_stall,
  input  dp_sts_t          sts,
  output ctl_cmd_t         cmd
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_ECHK = 3'd2;
  localparam logic [2:0] S_EMOV = 3'd3;
  localparam logic [2:0] S_APP  = 3'd4;
  localparam logic [2:0] S_FILL = 3'd5;
  localparam logic [2:0] S_RSP  = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_stall  = (state_r != S_IDLE);
    case (state_r)
      S_CLR: begin
        // After reset every position entry is swept to absent.
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          case (in_action)
            ACT_FILL: begin
              cmd.sweep_start = 1'b1;
              state_nxt       = S_FILL;
            end
            ACT_APPEND: state_nxt = S_APP;
            ACT_ERASE: begin
              if (sts.in_range) begin
                cmd.slot_rd = 1'b1;
                state_nxt   = S_ECHK;
              end else begin
                state_nxt = S_RSP;
              end
            end
            default: state_nxt = S_RSP;
          endcase
        end
      end
      S_ECHK: begin
        cmd.chk   = 1'b1;
        state_nxt = S_EMOV;
      end
      S_EMOV: begin
        if (sts.out_free) begin
          cmd.mov   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_APP: begin
        if (sts.out_free) begin
          cmd.app   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_FILL: begin
        cmd.sweep_step = 1'b1;
        cmd.sweep_fill = 1'b1;
        if (sts.sweep_last) state_nxt = S_RSP;
      end
      S_RSP: begin
        if (sts.out_free) begin
          cmd.rsp   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: src/isse_dp.sv
// Datapath: member list and position memories, count, sweep index and result register.
module isse_dp import isse_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  in_item_t          in_data,
  input  logic              cfg_we,
  input  logic [UNIV_W-1:0] cfg_wdata,
  input  ctl_cmd_t          cmd,
  output dp_sts_t           sts,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data
);

  logic [IDX_W:0]      slot_mem [MAX_ELEMS];
  logic [ELEM_W-1:0]   list_mem [MAX_ELEMS];
  logic [IDX_W:0]      slot_rd_q;
  logic [ELEM_W-1:0]   list_rd_q;

  logic [UNIV_W-1:0]   universe_r;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [ACT_W-1:0]    action_r;
  logic [ELEM_W-1:0]   element_r;
  logic [CNT_W-1:0]    fill_n_r;
  logic                hit_r;
  logic [IDX_W-1:0]    pos_r;
  out_item_t           out_data_r;

  logic [CNT_W-1:0]    last;
  logic [CNT_W-1:0]    fill_n;
  logic                hit_nxt;
  logic                move;
  logic                m_ok;
  logic                elem_ok;
  logic                full;
  logic                app_ok;
  logic                commit;
  out_item_t           res;

  logic                slot_we;
  logic [IDX_W-1:0]    slot_wa;
  logic [IDX_W:0]      slot_wd;
  logic                list_we;
  logic [IDX_W-1:0]    list_wa;
  logic [ELEM_W-1:0]   list_wd;

  assign last    = CNT_W'(count_r - CNT_W'(1));
  assign fill_n  = (32'(universe_r) > 32'(MAX_ELEMS)) ? CNT_W'(MAX_ELEMS) : CNT_W'(universe_r);
  assign hit_nxt = slot_rd_q[IDX_W] && (CNT_W'(slot_rd_q[IDX_W-1:0]) < count_r);
  assign move    = hit_r && (CNT_W'(pos_r) != last);
  assign m_ok    = 32'(list_rd_q) < 32'(MAX_ELEMS);
  assign elem_ok = 32'(element_r) < 32'(MAX_ELEMS);
  assign full    = count_r >= CNT_W'(MAX_ELEMS);
  assign app_ok  = elem_ok && !full;
  assign commit  = cmd.mov || cmd.app || cmd.rsp;

  assign sts.out_free   = !out_valid_r || !out_stall;
  assign sts.sweep_last = (idx_r == IDX_W'(MAX_ELEMS - 1));
  assign sts.in_range   = 32'(in_data.element) < 32'(MAX_ELEMS);

  // Only one command touches each memory in a given cycle.
  always_comb begin
    slot_we = 1'b0;
    slot_wa = idx_r;
    slot_wd = '0;
    list_we = 1'b0;
    list_wa = idx_r;
    list_wd = ELEM_W'(idx_r);
    if (cmd.sweep_step) begin
      slot_we = 1'b1;
      slot_wd = {cmd.sweep_fill && (CNT_W'(idx_r) < fill_n_r), idx_r};
      list_we = cmd.sweep_fill;
    end else if (cmd.chk) begin
      // The erased element goes absent whether or not it was a member.
      slot_we = 1'b1;
      slot_wa = IDX_W'(element_r);
      slot_wd = '0;
    end else if (cmd.mov) begin
      slot_we = move && m_ok;
      slot_wa = IDX_W'(list_rd_q);
      slot_wd = {1'b1, pos_r};
      list_we = move;
      list_wa = pos_r;
      list_wd = list_rd_q;
    end else if (cmd.app) begin
      slot_we = app_ok;
      slot_wa = IDX_W'(element_r);
      slot_wd = {1'b1, IDX_W'(count_r)};
      list_we = app_ok;
      list_wa = IDX_W'(count_r);
      list_wd = element_r;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    if (cmd.slot_rd) slot_rd_q <= slot_mem[IDX_W'(in_data.element)];
  end

  always_ff @(posedge clk) begin
    if (list_we) list_mem[list_wa] <= list_wd;
    if (cmd.chk) list_rd_q <= list_mem[IDX_W'(last)];
  end

  always_comb begin
    res.status        = STAT_DONE;
    res.member_count  = OCNT_W'(count_r);
    res.moved_element = element_r;
    if (cmd.mov) begin
      res.status       = hit_r ? STAT_DONE : STAT_ABSENT;
      res.member_count = hit_r ? OCNT_W'(last) : OCNT_W'(count_r);
      if (move) res.moved_element = list_rd_q;
    end else if (cmd.app) begin
      res.status       = app_ok ? STAT_DONE : STAT_REJECT;
      res.member_count = app_ok ? OCNT_W'(count_r + CNT_W'(1)) : OCNT_W'(count_r);
    end else if (action_r == ACT_FILL) begin
      res.member_count = OCNT_W'(fill_n_r);
    end else begin
      res.status = STAT_REJECT;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.mov && hit_r) count_nxt = last;
    else if (cmd.app && app_ok) count_nxt = CNT_W'(count_r + CNT_W'(1));
    else if (cmd.rsp && action_r == ACT_FILL) count_nxt = fill_n_r;

    idx_nxt = idx_r;
    if (cmd.sweep_start) idx_nxt = '0;
    else if (cmd.sweep_step) idx_nxt = IDX_W'(idx_r + IDX_W'(1));

    out_valid_nxt = out_valid_r;
    if (commit) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      universe_r  <= UNIV_RESET;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) universe_r <= cfg_wdata;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      action_r  <= in_data.action;
      element_r <= in_data.element;
    end
    if (cmd.sweep_start) fill_n_r <= fill_n;
    if (cmd.chk) begin
      hit_r <= hit_nxt;
      pos_r <= slot_rd_q[IDX_W-1:0];
    end
    if (commit) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: src/indexed_set_swap_erase_top.sv
// From accept to the result beat: append goes through S_APP, an unused code or out-of-range
// erase through S_RSP; erase does dependent position and list reads in S_IDLE and S_ECHK and
// commits in S_EMOV; fill sweeps one entry a cycle in S_FILL, then responds in S_RSP. One
// command is taken at a time; a result beat held by out_stall holds the next command in its
// final state. After reset a clearing pass marks all MAX_ELEMS positions absent with
// in_stall high. Configuration writes are taken in every cycle, also during the clearing pass.
`include "indexed_set_swap_erase_top_assert.svh"
module indexed_set_swap_erase_top import isse_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_we,
  input  logic [UNIV_W-1:0] cfg_wdata
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  isse_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_action(in_data.action),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  isse_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  `ISSE_ASSERT(a_one_cmd_beat, clk, rst_n, (in_valid && !in_stall) |=> in_stall, "beat accepted while busy")
  `ISSE_ASSERT(a_rise_after_busy, clk, rst_n, $rose(out_valid) |-> $past(in_stall), "result without a command")
  `ISSE_ASSERT(a_count_bound, clk, rst_n, out_valid |-> (out_data.member_count <= OCNT_W'(MAX_ELEMS)), "count above capacity")
  `ISSE_ASSERT_ALWAYS(a_single_action, clk, !rst_n || $onehot0({cmd.mov, cmd.app, cmd.rsp, cmd.sweep_step, cmd.chk}), "conflicting commands")

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the indexed set block with swap-on-erase.
`timescale 1ns / 100ps
module tb_top;
  import isse_pkg::*;

  // Action code 3 has no meaning in the block and must be rejected.
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = MAX_ELEMS + 16;

  // Tracks the set contents and holds the result beats still to arrive.
  class set_tracker;
    out_item_t         pending_q[$];
    int                errors;
    logic [UNIV_W-1:0] universe;
    logic [ELEM_W-1:0] members[MAX_ELEMS];
    logic [CNT_W-1:0]  slot_of[MAX_ELEMS];
    bit                present[MAX_ELEMS];
    logic [CNT_W-1:0]  count;

    function new();
      universe = UNIV_RESET;
      count = '0;
      errors = 0;
      foreach (present[i]) present[i] = 1'b0;
    endfunction

    function void note_command(in_item_t cmd);
      out_item_t        r;
      logic [CNT_W-1:0] n;
      logic [CNT_W-1:0] pos;
      logic [CNT_W-1:0] last;
      logic [ELEM_W-1:0] m;
      r.status = STAT_DONE;
      r.moved_element = cmd.element;
      case (cmd.action)
        ACT_FILL: begin
          n = (universe > UNIV_W'(MAX_ELEMS)) ? CNT_W'(MAX_ELEMS) : universe;
          for (int i = 0; i < MAX_ELEMS; i++) begin
            if (i < int'(n)) begin
              members[IDX_W'(i)] = ELEM_W'(i);
              slot_of[IDX_W'(i)] = CNT_W'(i);
              present[IDX_W'(i)] = 1'b1;
            end else begin
              present[IDX_W'(i)] = 1'b0;
            end
          end
          count = n;
        end
        ACT_APPEND: begin
          if (int'(cmd.element) >= MAX_ELEMS || count >= CNT_W'(MAX_ELEMS)) begin
            r.status = STAT_REJECT;
          end else begin
            members[IDX_W'(count)] = cmd.element;
            slot_of[cmd.element] = count;
            present[cmd.element] = 1'b1;
            count = count + CNT_W'(1);
          end
        end
        ACT_ERASE: begin
          if (int'(cmd.element) >= MAX_ELEMS) begin
            r.status = STAT_REJECT;
          end else if (!present[cmd.element] || slot_of[cmd.element] >= count) begin
            // A stale position is treated as absent and dropped.
            present[cmd.element] = 1'b0;
            r.status = STAT_ABSENT;
          end else begin
            pos = slot_of[cmd.element];
            last = count - CNT_W'(1);
            present[cmd.element] = 1'b0;
            if (pos != last) begin
              m = members[IDX_W'(last)];
              members[IDX_W'(pos)] = m;
              slot_of[m] = pos;
              present[m] = 1'b1;
              r.moved_element = m;
            end
            count = last;
          end
        end
        default: r.status = STAT_REJECT;
      endcase
      r.member_count = OCNT_W'(count);
      pending_q = {pending_q, r};
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result beat with nothing expected: status %0d count %0d moved %0d",
                   $realtime, got.status, got.member_count, got.moved_element);
      end else begin
        want = pending_q.pop_front();
        if (got.status !== want.status || got.member_count !== want.member_count ||
            got.moved_element !== want.moved_element) begin
          errors++;
          if (errors <= 10)
            $display("%0t: mismatch: status %0d/%0d count %0d/%0d moved %0d/%0d (exp/act)",
                     $realtime, want.status, got.status, want.member_count,
                     got.member_count, want.moved_element, got.moved_element);
        end
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_item_t          in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_data;
  logic              cfg_we = 1'b0;
  logic [UNIV_W-1:0] cfg_wdata = '0;

  bit         idle_on = 1'b1;
  set_tracker tracker = new();

  indexed_set_swap_erase_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= idle_on && ($urandom_range(99) < 34);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_result(out_data);
  end

  // Called right after a rising edge; returns at the edge that accepts the beat.
  task automatic send_command(input in_item_t cmd);
    if (idle_on && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 34);
    end
    in_valid <= 1'b1;
    in_data <= cmd;
    do @(posedge clk); while (in_stall);
    tracker.note_command(cmd);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_universe(input logic [UNIV_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.universe = value;
  endtask

  function automatic in_item_t random_command(input int unsigned pool_max);
    in_item_t    c;
    int unsigned pick;
    pick = $urandom_range(99);
    c.element = ELEM_W'($urandom_range(pool_max));
    if (pick < 2) begin
      c.action = ACT_FILL;
    end else if (pick < 48) begin
      c.action = ACT_APPEND;
    end else if (pick < 92) begin
      c.action = ACT_ERASE;
    end else if (pick < 96) begin
      c.action = ACT_UNUSED;
    end else begin
      c.action = ($urandom_range(1) != 0) ? ACT_APPEND : ACT_ERASE;
      c.element = ELEM_W'($urandom_range(MAX_ELEMS - 1));
    end
    return c;
  endfunction

  function automatic in_item_t make_cmd(input logic [ACT_W-1:0] act,
                                        input logic [ELEM_W-1:0] elem);
    in_item_t c;
    c.action  = act;
    c.element = elem;
    return c;
  endfunction

  initial begin
    in_item_t          directed[$];
    logic [UNIV_W-1:0] universes[8];
    int unsigned       pools[3];
    int unsigned       pool_max;
    in_item_t          fill_cmd;

    universes = '{11'd0, 11'd1, 11'd2047, 11'd1023, 11'd1025, 11'd5, 11'd0, 11'd16};
    universes[6] = UNIV_W'($urandom_range(2047));
    pools = '{7, 31, MAX_ELEMS - 1};
    fill_cmd = '{action: ACT_FILL, element: 10'h155};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Duplicates, stale list entries, a full list and the unused code at the reset universe.
    directed = {directed, make_cmd(ACT_ERASE, 10'd5)};
    directed = {directed, make_cmd(ACT_UNUSED, 10'd1023)};
    directed = {directed, make_cmd(ACT_APPEND, 10'd1023)};
    directed = {directed, make_cmd(ACT_APPEND, 10'd0)};
    directed = {directed, make_cmd(ACT_APPEND, 10'd1023)};
    directed = {directed, make_cmd(ACT_ERASE, 10'd0)};
    directed = {directed, make_cmd(ACT_ERASE, 10'd1023)};
    directed = {directed, make_cmd(ACT_ERASE, 10'd1023)};
    directed = {directed, make_cmd(ACT_FILL, 10'h3FF)};
    directed = {directed, make_cmd(ACT_APPEND, 10'd7)};
    directed = {directed, make_cmd(ACT_ERASE, 10'd1023)};
    directed = {directed, make_cmd(ACT_ERASE, 10'd0)};
    directed = {directed, make_cmd(ACT_ERASE, 10'd0)};
    directed = {directed, make_cmd(ACT_APPEND, 10'd0)};
    directed = {directed, make_cmd(ACT_APPEND, 10'd512)};
    directed = {directed, make_cmd(ACT_APPEND, 10'd3)};
    directed = {directed, make_cmd(ACT_UNUSED, 10'h2AA)};
    directed = {directed, make_cmd(ACT_ERASE, 10'd512)};
    directed = {directed, make_cmd(ACT_ERASE, 10'd512)};
    directed = {directed, make_cmd(ACT_ERASE, 10'd1)};
    foreach (directed[i]) send_command(directed[i]);

    for (int p = 0; p < 8; p++) begin
      wait_drained();
      write_universe(universes[p]);
      idle_on = (p != 3);
      pool_max = pools[p % 3];
      send_command(fill_cmd);
      repeat (60) send_command(random_command(pool_max));
    end
    idle_on = 1'b1;

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/isse_pkg.sv
src/isse_ctrl.sv
src/isse_dp.sv
src/indexed_set_swap_erase_top.sv
tb/tb_top.sv
